@@ hdl/slotsch_pkg.sv @@
// Shared types and constants for the slot scheduler with sleep timers.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package slotsch_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_ID_W   = 5;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 2;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_SLEEP = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_ACTIVE = 2'd1,
    SLOT_SLEEP  = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWP_RD,
    ST_SWP_EV,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic sweep_start;
    logic exec_single;
    logic eval;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic  req_valid;
    mode_t mode;
    logic  out_free;
    logic  eval_stall;
    logic  idx_last;
    logic  pend_valid;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/slotsch_if.sv @@
// Valid/ready channel interfaces for request and result beats.
// Depends on slotsch_pkg for field widths.
`default_nettype none

interface slotsch_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [slotsch_pkg::SLOT_ID_W-1:0]   slot_id;
  logic signed [slotsch_pkg::TIME_W-1:0] delay_ms;
  logic [slotsch_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, mode, slot_id, delay_ms, now_ms, input ready);
  modport sink   (input valid, mode, slot_id, delay_ms, now_ms, output ready);
endinterface

interface slotsch_out_if;
  logic                                valid;
  logic                                ready;
  logic [slotsch_pkg::STATUS_W-1:0]    status;
  logic [slotsch_pkg::SLOT_ID_W-1:0]   slot_num;
  logic                                dispatch;
  logic                                last;

  modport source (output valid, status, slot_num, dispatch, last, input ready);
  modport sink   (input valid, status, slot_num, dispatch, last, output ready);
endinterface

`default_nettype wire

@@ hdl/slotsch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slotsch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/slotsch_ctrl.sv @@
// Controller state machine: sequences requests and the slot sweep.
// Depends on slotsch_pkg; talks to the datapath only through command and status.
`default_nettype none

module slotsch_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire slotsch_pkg::dp_sts_t  sts,
  output slotsch_pkg::ctl_cmd_t      cmd
);
  import slotsch_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.req_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_SWEEP) begin
          state_nxt = ST_SWP_RD;
        end else if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWP_RD: state_nxt = ST_SWP_EV;
      ST_SWP_EV: begin
        if (!sts.eval_stall) begin
          state_nxt = sts.idx_last ? ST_FLUSH : ST_SWP_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: cmd.in_ready = 1'b1;
      ST_DECODE: begin
        if (sts.mode == MODE_SWEEP) begin
          cmd.sweep_start = 1'b1;
        end else begin
          cmd.exec_single = sts.out_free;
        end
      end
      ST_SWP_RD: ;
      ST_SWP_EV: cmd.eval  = !sts.eval_stall;
      ST_FLUSH:  cmd.flush = sts.pend_valid && sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/slotsch_dp.sv @@
// Datapath: slot state table, delay/time RAM, sweep index, pending dispatch
// and the output register. Depends on slotsch_pkg, slotsch_if and slotsch_ram.
`default_nettype none

module slotsch_dp #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  slotsch_in_if.sink                 in_ch,
  slotsch_out_if.source              out_ch,
  input  wire slotsch_pkg::ctl_cmd_t cmd,
  output slotsch_pkg::dp_sts_t       sts
);
  import slotsch_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDP_W = IDX_W + 1;

  // Latched request.
  mode_t                mode_r;
  logic [SLOT_ID_W-1:0] slot_id_r;
  logic [TIME_W-1:0]    dly_r;
  logic [TIME_W-1:0]    now_r;

  slot_st_t slot_st_r [SLOT_COUNT];

  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pend_valid_r;
  logic [SLOT_ID_W-1:0] pend_slot_r;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_ID_W-1:0] out_slot_r;
  logic                 out_disp_r;
  logic                 out_last_r;

  logic                    ram_we;
  logic [2*TIME_W-1:0]     ram_wdata;
  logic [2*TIME_W-1:0]     ram_rdata;

  logic [SLOT_ID_W-1:0] sid_m1;
  logic [IDX_W-1:0]     sid_idx;
  logic                 sid_in_range;
  logic [IDX_W-1:0]     sel_idx;
  slot_st_t             st_sel;
  logic                 sleep_ok;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [TIME_W-1:0]    elapsed;
  logic [TIME_W-1:0]    dly_new;
  logic                 ev_wake;
  logic                 ev_run;
  logic                 ev_report;
  logic                 out_free;
  logic                 push;
  logic                 load;
  logic [STATUS_W-1:0]  ld_status;
  logic [SLOT_ID_W-1:0] ld_slot;
  logic                 ld_disp;
  logic                 ld_last;
  logic [STATUS_W-1:0]  single_status;
  logic [SLOT_ID_W-1:0] single_slot;

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      mode_r    <= mode_t'(in_ch.mode);
      slot_id_r <= in_ch.slot_id;
      dly_r     <= $unsigned(in_ch.delay_ms);
      now_r     <= in_ch.now_ms;
    end
  end

  assign in_ch.ready = cmd.in_ready;

  always_comb begin
    sid_m1       = slot_id_r - SLOT_ID_W'(1);
    sid_idx      = IDX_W'(sid_m1);
    sid_in_range = (slot_id_r != '0) && (32'(slot_id_r) <= 32'(SLOT_COUNT));
    sel_idx      = (mode_r == MODE_SWEEP) ? idx_r : sid_idx;
    st_sel       = slot_st_r[sel_idx];
    sleep_ok     = sid_in_range && (st_sel != SLOT_FREE);
  end

  // Lowest free slot: scanning downward leaves the lowest hit.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_st_r[i] == SLOT_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Sweep evaluation of the slot whose RAM word was read last cycle.
  always_comb begin
    elapsed   = now_r - ram_rdata[TIME_W-1:0];
    dly_new   = ram_rdata[2*TIME_W-1:TIME_W] - elapsed;
    ev_wake   = (st_sel == SLOT_SLEEP) && ((dly_new == '0) || dly_new[TIME_W-1]);
    ev_run    = (st_sel == SLOT_ACTIVE) || ev_wake;
    ev_report = ev_run && (cnt_r < CNT_W'(MAX_RESULTS));
  end

  always_comb begin
    single_status = STATUS_INVALID;
    single_slot   = '0;
    unique case (mode_r)
      MODE_ALLOC: begin
        if (free_found) begin
          single_status = STATUS_OK;
          single_slot   = SLOT_ID_W'(IDP_W'(free_idx) + IDP_W'(1));
        end else begin
          single_status = STATUS_NO_FREE;
        end
      end
      MODE_SLEEP: begin
        if (sleep_ok) begin
          single_status = STATUS_OK;
          single_slot   = slot_id_r;
        end
      end
      MODE_SWEEP, MODE_UNUSED: ;
      default: ;
    endcase
  end

  // RAM word: {remaining delay, last-seen time}.
  assign ram_we    = (cmd.exec_single && (mode_r == MODE_SLEEP) && sleep_ok) ||
                     (cmd.eval && (st_sel == SLOT_SLEEP));
  assign ram_wdata = {((mode_r == MODE_SLEEP) ? dly_r : dly_new), now_r};

  slotsch_ram #(
    .WIDTH (2 * TIME_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_idx),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st_r[i] <= SLOT_FREE;
      end
    end else if (cmd.exec_single && (mode_r == MODE_ALLOC) && free_found) begin
      slot_st_r[free_idx] <= SLOT_ACTIVE;
    end else if (cmd.exec_single && (mode_r == MODE_SLEEP) && sleep_ok) begin
      slot_st_r[sel_idx] <= SLOT_SLEEP;
    end else if (cmd.eval && ev_wake) begin
      slot_st_r[sel_idx] <= SLOT_ACTIVE;
    end
  end

  // A dispatch is held back one step so the final beat of a sweep can carry last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.eval) begin
      idx_r <= idx_r + IDX_W'(1);
      if (ev_report) begin
        cnt_r        <= cnt_r + CNT_W'(1);
        pend_valid_r <= 1'b1;
      end
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && ev_report) begin
      pend_slot_r <= SLOT_ID_W'(IDP_W'(sel_idx) + IDP_W'(1));
    end
  end

  // Output register.
  assign out_free = !out_valid_r || out_ch.ready;
  assign push     = cmd.eval && ev_report && pend_valid_r;
  assign load     = cmd.exec_single || push || cmd.flush;

  always_comb begin
    ld_status = STATUS_OK;
    ld_slot   = pend_slot_r;
    ld_disp   = 1'b1;
    ld_last   = cmd.flush;
    if (cmd.exec_single) begin
      ld_status = single_status;
      ld_slot   = single_slot;
      ld_disp   = 1'b0;
      ld_last   = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_slot_r   <= ld_slot;
      out_disp_r   <= ld_disp;
      out_last_r   <= ld_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.slot_num = out_slot_r;
  assign out_ch.dispatch = out_disp_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    sts            = '0;
    sts.req_valid  = in_ch.valid;
    sts.mode       = mode_r;
    sts.out_free   = out_free;
    sts.eval_stall = ev_report && pend_valid_r && !out_free;
    sts.idx_last   = (idx_r == IDX_W'(SLOT_COUNT - 1));
    sts.pend_valid = pend_valid_r;
  end

endmodule

`default_nettype wire

@@ hdl/slot_scheduler_with_sleep_timers.sv @@
// Slot scheduler with sleep timers, top level.
// Allocate, sleep and unused-mode requests each give one result beat, loaded into the
// output register from the decode state once the result channel is free; the next request is accepted after that.
// A sweep reads each slot's RAM word, then evaluates it and writes back, and ends in the
// flush state for the pending dispatch; the sweep waits while the result channel stalls.
// One request is in flight at a time; the next is accepted once it completes.
// Synchronous active-low reset marks every slot free; no clearing pass is needed.
`default_nettype none

module slot_scheduler_with_sleep_timers #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  slotsch_in_if.sink    in_ch,
  slotsch_out_if.source out_ch
);
  import slotsch_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  slotsch_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  slotsch_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire
